### rtl/core/ptsr_pkg.sv
// Shared types and constants of the packed table with swap-remove.
// Used by every module in rtl/core; depends on nothing else.
`default_nettype none

package ptsr_pkg;

    localparam int ENTITY_W  = 8;
    localparam int SLOT_W    = 8;
    localparam int COUNT_W   = SLOT_W + 1;
    localparam int VALUE_W   = 32;
    localparam int NUM_SLOTS = 1 << SLOT_W;
    localparam int NUM_ENTS  = 1 << ENTITY_W;

    localparam logic [1:0] CMD_ADD    = 2'd0;
    localparam logic [1:0] CMD_DELETE = 2'd1;
    localparam logic [1:0] CMD_GET    = 2'd2;
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_ABSENT  = 2'd1,
        ST_FULL    = 2'd2,
        ST_PRESENT = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        OP_ADD,
        OP_DEL,
        OP_GET,
        OP_NOP
    } t_op;

    typedef enum logic [1:0] {
        S_IDLE,
        S_GET_SLOT,
        S_GET_VALUE,
        S_DEL_MOVE
    } t_state;

    typedef struct packed {
        t_op                 op;
        logic [ENTITY_W-1:0] entity;
        logic [VALUE_W-1:0]  value;
    } t_item;

    typedef struct packed {
        t_status             status;
        logic [VALUE_W-1:0]  value;
        logic [SLOT_W-1:0]   slot;
        logic [COUNT_W-1:0]  count;
    } t_result;

endpackage

`default_nettype wire

### rtl/core/packed_table_swap_remove.sv
// Top level of the packed value store with swap-remove.
// Instantiates ptsr_front, ptsr_back and ptsr_out_q; depends on ptsr_pkg.
//
// Each entity (0 to 255) may own one 32-bit value; values sit packed in slots
// 0 to used_count-1, and a delete moves the last slot into the freed one, so
// slot numbers of other entities can change. Every command gives one result.
// An add, an unused command code and any refused command finish in S_IDLE of
// the back end, a delete also passes S_DEL_MOVE and a get S_GET_SLOT and
// S_GET_VALUE: the entity-to-slot map and the value memory each have a
// registered read port, and a get reads them one after the other. Two-entry
// queues sit on the command and result sides, so commands can be pushed while
// results wait to be popped. No clearing pass is needed after reset.
`default_nettype none

module packed_table_swap_remove
    import ptsr_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                push,
    output logic                     full,
    input  wire logic [1:0]          i_command,
    input  wire logic [ENTITY_W-1:0] i_entity_id,
    input  wire logic [VALUE_W-1:0]  i_new_value,
    output logic                     empty,
    input  wire logic                pop,
    output logic [1:0]               o_status,
    output logic [VALUE_W-1:0]       o_read_value,
    output logic [SLOT_W-1:0]        o_slot_index,
    output logic [COUNT_W-1:0]       o_used_count
);

    logic    item_valid;
    t_item   item;
    logic    take;
    logic    res_room;
    logic    res_push;
    t_result res_in;
    t_result res_out;

    ptsr_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .push         (push),
        .full         (full),
        .i_command    (i_command),
        .i_entity_id  (i_entity_id),
        .i_new_value  (i_new_value),
        .o_item_valid (item_valid),
        .o_item       (item),
        .i_take       (take)
    );

    ptsr_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_valid (item_valid),
        .i_item       (item),
        .o_take       (take),
        .i_res_room   (res_room),
        .o_res_push   (res_push),
        .o_res        (res_in)
    );

    ptsr_out_q u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_res   (res_in),
        .o_room  (res_room),
        .empty   (empty),
        .pop     (pop),
        .o_res   (res_out)
    );

    assign o_status     = res_out.status;
    assign o_read_value = res_out.value;
    assign o_slot_index = res_out.slot;
    assign o_used_count = res_out.count;

endmodule

`default_nettype wire

### rtl/core/ptsr_front.sv
// Front end: input queue that takes commands and classifies them into operations.
// Depends on ptsr_pkg.
`default_nettype none

module ptsr_front
    import ptsr_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                push,
    output logic                     full,
    input  wire logic [1:0]          i_command,
    input  wire logic [ENTITY_W-1:0] i_entity_id,
    input  wire logic [VALUE_W-1:0]  i_new_value,
    output logic                     o_item_valid,
    output t_item                    o_item,
    input  wire logic                i_take
);

    t_item       r_entry [2];
    logic        r_wr_ptr;
    logic        r_rd_ptr;
    logic [1:0]  r_count;
    logic [1:0]  n_count;
    logic        w_wr;
    logic        w_rd;
    t_op         w_op;

    always_comb begin
        unique case (i_command)
            CMD_ADD:    w_op = OP_ADD;
            CMD_DELETE: w_op = OP_DEL;
            CMD_GET:    w_op = OP_GET;
            CMD_UNUSED: w_op = OP_NOP;
            default:    w_op = OP_NOP;
        endcase
    end

    assign full         = (r_count == 2'd2);
    assign o_item_valid = (r_count != 2'd0);
    assign o_item       = r_entry[r_rd_ptr];
    assign w_wr         = push && !full;
    assign w_rd         = i_take && o_item_valid;

    always_comb begin
        n_count = r_count;
        if (w_wr && !w_rd) begin
            n_count = r_count + 2'd1;
        end else if (w_rd && !w_wr) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_count <= n_count;
            if (w_wr) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (w_rd) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_entry[r_wr_ptr] <= '{op: w_op, entity: i_entity_id, value: i_new_value};
        end
    end

endmodule

`default_nettype wire

### rtl/core/ptsr_back.sv
// Back end: sequencer that carries out add, delete and get against the
// entity map, owner map and value memories. Depends on ptsr_pkg.
`default_nettype none

module ptsr_back
    import ptsr_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_item_valid,
    input  wire t_item   i_item,
    output logic         o_take,
    input  wire logic    i_res_room,
    output logic         o_res_push,
    output t_result      o_res
);

    logic [SLOT_W-1:0]   mem_es [NUM_ENTS];
    logic [ENTITY_W-1:0] mem_so [NUM_SLOTS];
    logic [VALUE_W-1:0]  mem_vs [NUM_SLOTS];

    logic [NUM_ENTS-1:0] r_present;
    logic [COUNT_W-1:0]  r_occ;
    t_state              r_state;
    t_state              n_state;
    logic [ENTITY_W-1:0] r_ent;
    logic [SLOT_W-1:0]   r_slot;
    logic [SLOT_W-1:0]   r_es_rd;
    logic [ENTITY_W-1:0] r_so_rd;
    logic [VALUE_W-1:0]  r_vs_rd;

    logic                w_start;
    logic                w_present;
    logic [COUNT_W-1:0]  w_last;
    logic                w_full;

    logic                es_we;
    logic [ENTITY_W-1:0] es_waddr;
    logic [SLOT_W-1:0]   es_wdata;
    logic                so_we;
    logic [SLOT_W-1:0]   so_waddr;
    logic [ENTITY_W-1:0] so_wdata;
    logic                vs_we;
    logic [SLOT_W-1:0]   vs_waddr;
    logic [VALUE_W-1:0]  vs_wdata;
    logic [SLOT_W-1:0]   vs_raddr;
    logic                pres_set;
    logic                pres_clr;
    logic                occ_inc;
    logic                occ_dec;

    assign w_start   = (r_state == S_IDLE) && i_item_valid && i_res_room;
    assign w_present = r_present[i_item.entity];
    assign w_last    = r_occ - COUNT_W'(1);
    assign w_full    = (r_occ == COUNT_W'(NUM_SLOTS));

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_start && w_present && i_item.op == OP_DEL) begin
                    n_state = S_DEL_MOVE;
                end else if (w_start && w_present && i_item.op == OP_GET) begin
                    n_state = S_GET_SLOT;
                end
            end
            S_GET_SLOT:  n_state = S_GET_VALUE;
            S_GET_VALUE: n_state = S_IDLE;
            S_DEL_MOVE:  n_state = S_IDLE;
            default:     n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_take     = 1'b0;
        o_res_push = 1'b0;
        o_res      = '{status: ST_OK, value: '0, slot: '0, count: r_occ};
        es_we      = 1'b0;
        es_waddr   = i_item.entity;
        es_wdata   = r_occ[SLOT_W-1:0];
        so_we      = 1'b0;
        so_waddr   = r_occ[SLOT_W-1:0];
        so_wdata   = i_item.entity;
        vs_we      = 1'b0;
        vs_waddr   = r_occ[SLOT_W-1:0];
        vs_wdata   = i_item.value;
        vs_raddr   = w_last[SLOT_W-1:0];
        pres_set   = 1'b0;
        pres_clr   = 1'b0;
        occ_inc    = 1'b0;
        occ_dec    = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (w_start) begin
                    o_take = 1'b1;
                    unique case (i_item.op)
                        OP_ADD: begin
                            o_res_push = 1'b1;
                            if (w_present) begin
                                o_res.status = ST_PRESENT;
                            end else if (w_full) begin
                                o_res.status = ST_FULL;
                            end else begin
                                es_we       = 1'b1;
                                so_we       = 1'b1;
                                vs_we       = 1'b1;
                                pres_set    = 1'b1;
                                occ_inc     = 1'b1;
                                o_res.slot  = r_occ[SLOT_W-1:0];
                                o_res.count = r_occ + COUNT_W'(1);
                            end
                        end
                        OP_DEL, OP_GET: begin
                            if (!w_present) begin
                                o_res_push   = 1'b1;
                                o_res.status = ST_ABSENT;
                            end
                        end
                        OP_NOP: begin
                            o_res_push = 1'b1;
                        end
                        default: begin
                            o_res_push = 1'b1;
                        end
                    endcase
                end
            end
            S_GET_SLOT: begin
                vs_raddr = r_es_rd;
            end
            S_GET_VALUE: begin
                o_res_push  = 1'b1;
                o_res.value = r_vs_rd;
                o_res.slot  = r_slot;
            end
            S_DEL_MOVE: begin
                // The last slot's value and owner move into the freed slot;
                // when they are the same slot this simply frees it.
                vs_we       = 1'b1;
                vs_waddr    = r_es_rd;
                vs_wdata    = r_vs_rd;
                es_we       = 1'b1;
                es_waddr    = r_so_rd;
                es_wdata    = r_es_rd;
                so_we       = 1'b1;
                so_waddr    = r_es_rd;
                so_wdata    = r_so_rd;
                pres_clr    = 1'b1;
                occ_dec     = 1'b1;
                o_res_push  = 1'b1;
                o_res.slot  = r_es_rd;
                o_res.count = w_last;
            end
            default: begin
                o_take = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_present <= '0;
            r_occ     <= '0;
        end else begin
            r_state <= n_state;
            if (pres_set) begin
                r_present[i_item.entity] <= 1'b1;
            end
            if (pres_clr) begin
                r_present[r_ent] <= 1'b0;
            end
            if (occ_inc) begin
                r_occ <= r_occ + COUNT_W'(1);
            end else if (occ_dec) begin
                r_occ <= w_last;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_ent <= i_item.entity;
        end
        if (r_state == S_GET_SLOT) begin
            r_slot <= r_es_rd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (es_we) begin
            mem_es[es_waddr] <= es_wdata;
        end
        r_es_rd <= mem_es[i_item.entity];
    end

    always_ff @(posedge i_clk) begin
        if (so_we) begin
            mem_so[so_waddr] <= so_wdata;
        end
        r_so_rd <= mem_so[w_last[SLOT_W-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (vs_we) begin
            mem_vs[vs_waddr] <= vs_wdata;
        end
        r_vs_rd <= mem_vs[vs_raddr];
    end

endmodule

`default_nettype wire

### rtl/core/ptsr_out_q.sv
// Result queue between the back end and the result ports.
// Depends on ptsr_pkg.
`default_nettype none

module ptsr_out_q
    import ptsr_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_push,
    input  wire t_result i_res,
    output logic         o_room,
    output logic         empty,
    input  wire logic    pop,
    output t_result      o_res
);

    t_result     r_entry [2];
    logic        r_wr_ptr;
    logic        r_rd_ptr;
    logic [1:0]  r_count;
    logic [1:0]  n_count;
    logic        w_wr;
    logic        w_rd;

    assign o_room = (r_count != 2'd2);
    assign empty  = (r_count == 2'd0);
    assign o_res  = r_entry[r_rd_ptr];
    assign w_wr   = i_push && o_room;
    assign w_rd   = pop && !empty;

    always_comb begin
        n_count = r_count;
        if (w_wr && !w_rd) begin
            n_count = r_count + 2'd1;
        end else if (w_rd && !w_wr) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_count <= n_count;
            if (w_wr) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (w_rd) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_entry[r_wr_ptr] <= i_res;
        end
    end

endmodule

`default_nettype wire
